@@ src/mphp_pkg.sv @@
// ============================================================================
// mphp_pkg
// Shared types and constants for the mesh packet header parser.
// ============================================================================
`default_nettype none

package mphp_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 512;
    localparam int OFFSET_MIN_W         = 10;   // holds a payload start plus four
    localparam int CFG_INDEX_W          = 3;
    localparam int CFG_DATA_W           = 7;
    localparam int OUT_DATA_W           = 88;

    localparam logic [2:0] PBI_PLAIN     = 3'd1;
    localparam logic [2:0] PBI_TRANSPORT = 3'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TRANSPORT_FLOOD  = 3'd0,
        CFG_TRANSPORT_DIRECT = 3'd1,
        CFG_TRACE_TYPE       = 3'd2,
        CFG_ADVERT_TYPE      = 3'd3,
        CFG_ADVERT_KEY_LEN   = 3'd4
    } cfg_reg_e;

    typedef enum logic [1:0] {
        ID_NONE       = 2'd0,
        ID_PATH_HASH  = 2'd1,
        ID_ADVERT_KEY = 2'd2
    } id_source_e;

    // Per-packet header state, also used as the end-of-packet snapshot
    typedef struct packed {
        logic [31:0] tag;
        logic        overlong;
        logic [2:0]  pbi;       // index of the path-length byte
        logic [2:0]  hash;
        logic [5:0]  hops;
        logic [3:0]  ptype;
        logic [1:0]  route;
    } pkt_state_t;

    localparam pkt_state_t PKT_CLEAR = '{
        tag:      32'd0,
        overlong: 1'b0,
        pbi:      PBI_PLAIN,
        hash:     3'd1,
        hops:     6'd0,
        ptype:    4'd0,
        route:    2'd0
    };

    // Packed from valid_packet (bit 0) up to trace_tag
    typedef struct packed {
        logic [31:0] trace_tag;
        logic        tag_valid;
        logic [6:0]  id_length;
        logic [8:0]  id_offset;
        id_source_e  id_source;
        logic [8:0]  payload_length;
        logic [8:0]  payload_offset;
        logic [2:0]  hash_size;
        logic [5:0]  hop_count;
        logic [3:0]  payload_kind;
        logic [1:0]  route_kind;
        logic        valid_packet;
    } summary_t;

    typedef struct packed {
        logic [1:0] flood_code;
        logic [1:0] direct_code;
        logic [3:0] trace_code;
        logic [3:0] advert_code;
        logic [6:0] key_length;
    } cfg_t;

endpackage

`default_nettype wire

@@ src/mesh_packet_header_parser.sv @@
// ============================================================================
// mesh_packet_header_parser
// Parses a mesh radio packet byte stream into one summary item per packet.
// ============================================================================
// Input channel s_axis: one packet byte per item, tlast on the final byte.
// Output channel m_axis: one summary item per packet, sent after its last
// byte. Configuration: cfg_we/cfg_index/cfg_data, written between packets.
//
// Throughput: one byte per cycle while s_axis_tready is high; the byte
// tracker accepts every cycle unless both stages are full. The summary
// passes through the snapshot register, then the output register.
// Bytes beyond MAX_PACKET_BYTES are dropped and the packet reports invalid.
//
// Reset clears the packet state, the snapshot and output valid flags and
// loads the register defaults. When m_axis_tready is low the summary holds;
// one more finished packet may wait in the snapshot stage, and s_axis_tready
// drops only while both stages are full.
// ============================================================================
`default_nettype none

module mesh_packet_header_parser
    import mphp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // data_byte
    input  wire logic                   s_axis_tlast,   // last_byte
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // valid_packet, route_kind, payload_kind, hop_count, hash_size,
    // payload_offset, payload_length, id_source, id_offset, id_length,
    // tag_valid, trace_tag, zero pad
    output      logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);

    cfg_t             cfg_reg, cfg_next;
    logic             accept, advance;
    logic             snap_valid;
    pkt_state_t       snap;
    logic [IDX_W-1:0] snap_len;
    summary_t         result;
    summary_t         out_reg;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_TRANSPORT_FLOOD:  cfg_next.flood_code  = cfg_data[1:0];
                CFG_TRANSPORT_DIRECT: cfg_next.direct_code = cfg_data[1:0];
                CFG_TRACE_TYPE:       cfg_next.trace_code  = cfg_data[3:0];
                CFG_ADVERT_TYPE:      cfg_next.advert_code = cfg_data[3:0];
                CFG_ADVERT_KEY_LEN:   cfg_next.key_length  = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{flood_code: 2'd0, direct_code: 2'd3, trace_code: 4'd9,
                         advert_code: 4'd4, key_length: 7'd32};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !snap_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mphp_tracker #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .IDX_W            (IDX_W)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_axis_tdata),
        .last_byte  (s_axis_tlast),
        .cfg        (cfg_reg),
        .advance    (advance),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_len   (snap_len)
    );

    mphp_summary #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .IDX_W            (IDX_W)
    ) u_summary (
        .snap   (snap),
        .len    (snap_len),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_comb
    begin
        if (advance)
            out_valid_next = snap_valid;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && snap_valid)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - $bits(summary_t))'(0), out_reg};

`ifndef NO_ASSERTIONS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid && !advance) |-> !s_axis_tready)
        else $error("input accepted with both stages full");

    a_last_makes_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=> snap_valid)
        else $error("last byte did not produce a snapshot");

    a_tag_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.tag_valid) |-> out_reg.valid_packet)
        else $error("trace tag on an invalid packet");

    a_id_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.id_source != ID_NONE) |-> out_reg.valid_packet)
        else $error("identifier on an invalid packet");

    a_invalid_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.valid_packet)
            |-> (out_reg.payload_offset == 9'd0 && out_reg.id_length == 7'd0))
        else $error("invalid packet carries offsets");
`endif

endmodule

`default_nettype wire

@@ src/mphp_tracker.sv @@
// ============================================================================
// mphp_tracker
// Per-byte header tracking; snapshots the packet state on the last byte.
// ============================================================================
`default_nettype none

module mphp_tracker
    import mphp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
    parameter int IDX_W            = $clog2(MAX_PACKET_BYTES + 1)
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    input  wire cfg_t             cfg,
    input  wire logic             advance,
    output      logic             snap_valid,
    output      pkt_state_t       snap,
    output      logic [IDX_W-1:0] snap_len
);

    localparam int CMP_W = (IDX_W > OFFSET_MIN_W) ? IDX_W : OFFSET_MIN_W;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_PACKET_BYTES);

    pkt_state_t       st_reg, st_next, st_upd;
    logic [IDX_W-1:0] idx_reg, idx_next, idx_upd;
    logic             snap_valid_reg, snap_valid_next;
    pkt_state_t       snap_reg;
    logic [IDX_W-1:0] snap_len_reg;

    logic [CMP_W-1:0] po_cur, idx_ext, lane_ofs;
    logic [IDX_W-1:0] pbi_ext;
    logic             in_tag;

    always_comb
    begin
        po_cur  = CMP_W'(st_reg.pbi) + CMP_W'(1)
                + CMP_W'(st_reg.hops) * CMP_W'(st_reg.hash);
        idx_ext  = CMP_W'(idx_reg);
        pbi_ext  = IDX_W'(st_reg.pbi);
        lane_ofs = idx_ext - po_cur;
        in_tag   = (idx_ext >= po_cur) && (idx_ext < po_cur + CMP_W'(4));

        st_upd  = st_reg;
        idx_upd = idx_reg;
        if (!st_reg.overlong && idx_reg < IDX_LIMIT)
        begin
            if (idx_reg == '0)
            begin
                st_upd.route = data_byte[1:0];
                st_upd.ptype = data_byte[5:2];
                st_upd.pbi   = (data_byte[1:0] == cfg.flood_code ||
                                data_byte[1:0] == cfg.direct_code)
                             ? PBI_TRANSPORT : PBI_PLAIN;
            end
            else if (idx_reg == pbi_ext)
            begin
                st_upd.hops = data_byte[5:0];
                st_upd.hash = {1'b0, data_byte[7:6]} + 3'd1;
            end
            else if (idx_reg > pbi_ext && in_tag)
            begin
                st_upd.tag = st_reg.tag | ({24'd0, data_byte} << {lane_ofs[1:0], 3'b000});
            end
            idx_upd = idx_reg + IDX_W'(1);
        end
        else
        begin
            st_upd.overlong = 1'b1;
        end

        st_next  = st_reg;
        idx_next = idx_reg;
        if (accept)
        begin
            st_next  = last_byte ? PKT_CLEAR : st_upd;
            idx_next = last_byte ? '0 : idx_upd;
        end

        if (accept && last_byte)
            snap_valid_next = 1'b1;
        else if (advance)
            snap_valid_next = 1'b0;
        else
            snap_valid_next = snap_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= PKT_CLEAR;
            idx_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            idx_reg        <= idx_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            snap_reg     <= st_upd;
            snap_len_reg <= idx_upd;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;
    assign snap_len   = snap_len_reg;

endmodule

`default_nettype wire

@@ src/mphp_summary.sv @@
// ============================================================================
// mphp_summary
// Builds the packet summary from the end-of-packet snapshot.
// ============================================================================
`default_nettype none

module mphp_summary
    import mphp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
    parameter int IDX_W            = $clog2(MAX_PACKET_BYTES + 1)
)(
    input  wire pkt_state_t       snap,
    input  wire logic [IDX_W-1:0] len,
    input  wire cfg_t             cfg,
    output      summary_t         result
);

    localparam int CMP_W = (IDX_W > OFFSET_MIN_W) ? IDX_W : OFFSET_MIN_W;

    logic [CMP_W-1:0] po, len_e, plen_full, hash_ofs;
    logic             valid;

    always_comb
    begin
        po        = CMP_W'(snap.pbi) + CMP_W'(1) + CMP_W'(snap.hops) * CMP_W'(snap.hash);
        len_e     = CMP_W'(len);
        plen_full = len_e - po;
        hash_ofs  = po - CMP_W'(snap.hash);
        valid     = !snap.overlong && len_e >= CMP_W'(2)
                 && len_e > CMP_W'(snap.pbi) && po <= len_e;

        result                = '0;
        result.valid_packet   = valid;
        result.route_kind     = snap.route;
        result.payload_kind   = snap.ptype;
        result.hop_count      = snap.hops;
        result.hash_size      = snap.hash;
        result.id_source      = ID_NONE;
        if (valid)
        begin
            result.payload_offset = po[8:0];
            result.payload_length = plen_full[8:0];
            if (snap.ptype == cfg.trace_code)
            begin
                if (plen_full >= CMP_W'(4))
                begin
                    result.tag_valid = 1'b1;
                    result.trace_tag = snap.tag;
                end
            end
            else if (snap.hops != 6'd0)
            begin
                result.id_source = ID_PATH_HASH;
                result.id_offset = hash_ofs[8:0];
                result.id_length = 7'(snap.hash);
            end
            else if (snap.ptype == cfg.advert_code && plen_full >= CMP_W'(cfg.key_length))
            begin
                result.id_source = ID_ADVERT_KEY;
                result.id_offset = po[8:0];
                result.id_length = cfg.key_length;
            end
        end
    end

endmodule

`default_nettype wire
